// ===== rtl/pulse_coincidence_clusterer_core_macros.svh =====
// Assertion macros for the pulse coincidence clusterer RTL.
// Included by the core, which checks its own control logic; needs clk and rst_n in scope.
`ifndef PULSE_COINCIDENCE_CLUSTERER_CORE_MACROS_SVH
`define PULSE_COINCIDENCE_CLUSTERER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define PCC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcc assertion failed");

// Next-cycle implication, disabled while in reset.
`define PCC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcc assertion failed");

`endif

// ===== rtl/pcc_pkg.sv =====
// Types and fixed constants of the pulse coincidence clusterer.
// No dependencies; imported by pulse_coincidence_clusterer_core and tb_top.
package pcc_pkg;

  localparam int CHANNELS   = 32;
  localparam int TIME_BITS  = 20;
  localparam int RESULT_CAP = 64;

  localparam logic [19:0] TIME_MASK =
    (TIME_BITS >= 20) ? 20'hFFFFF : 20'((64'd1 << TIME_BITS) - 64'd1);
  localparam logic [25:0] AMP_MAX = 26'h3FFFFFF;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_END  = 1'b1;

  localparam logic [1:0] SIG_S1   = 2'd0;
  localparam logic [1:0] SIG_S2   = 2'd1;
  localparam logic [1:0] SIG_NONE = 2'd2;

  localparam logic [1:0] CFG_MIN_S1_PULSES = 2'd0;
  localparam logic [1:0] CFG_MIN_S2_PULSES = 2'd1;
  localparam logic [1:0] CFG_MAX_S1_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_MIN_S2_WIDTH  = 2'd3;

  typedef struct packed {
    logic        op;
    logic [4:0]  channel;
    logic [19:0] pulse_start;
    logic [19:0] pulse_end;
    logic [19:0] pulse_amplitude;
  } in_item_t;

  typedef struct packed {
    logic        has_signal;
    logic [19:0] sig_start;
    logic [19:0] sig_end;
    logic [25:0] sig_amplitude;
    logic [6:0]  pulse_count;
    logic [1:0]  sig_type;
    logic        dropped;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [4:0]  chan;
    logic [19:0] start;
    logic [19:0] stop;
    logic [19:0] amp;
  } pulse_rec_t;

endpackage

// ===== rtl/pulse_coincidence_clusterer_core.sv =====
// Pulse coincidence clusterer: loads an event's PMT pulses and groups them into signals.
// Depends on pcc_pkg and pulse_coincidence_clusterer_core_macros.svh.
//
// Usage:
//   Input requests (valid/ready) carry either one pulse (op load) or the end of an
//   event (op end). Pulses arrive ordered by channel, then by start time. A load
//   stores one pulse; pulses past MAX_PULSES are dropped and flag the event.
//   An end request starts clustering out of the pulse memory: each unmerged seed
//   is followed by a scan over every later pulse and a finishing step, a merged
//   seed is skipped, and the single read port of the pulse memory serves one pulse
//   at a time.
//   Results leave on the output channel (valid/ready) through one output
//   register; the final result of an event carries last, and an event with no
//   kept signal yields one empty marker. A stalled receiver holds the clusterer
//   at its next result; a new request is taken as soon as the last result of the
//   event sits in the output register.
//   Configuration writes (cfg_we, cfg_index, cfg_data) are registered; the user must
//   make them only while the block is idle, which the block does not enforce.
//   Reset (rst_n low, synchronous) empties the pulse store, clears the overflow
//   flag and restores thresholds 1, 1, 3000, 4000. No clearing pass is needed.
module pulse_coincidence_clusterer_core
  import pcc_pkg::*;
#(
  parameter int MAX_PULSES = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data
);

  localparam int AW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
  localparam int CW = $clog2(MAX_PULSES + 1);
  localparam int KW = (CW > 7) ? CW : 7;
  localparam int RW = $clog2(RESULT_CAP + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEED   = 3'd1;
  localparam logic [2:0] S_SCAN   = 3'd2;
  localparam logic [2:0] S_FINISH = 3'd3;
  localparam logic [2:0] S_END    = 3'd4;

  // memories
  pulse_rec_t pulse_mem [MAX_PULSES];
  logic       flag_mem  [MAX_PULSES];
  pulse_rec_t pulse_q;
  logic       flag_q;
  logic [AW-1:0] rd_addr;
  logic          pulse_we;
  logic          flag_we;
  logic          flag_wd;
  logic [AW-1:0] flag_wa;
  pulse_rec_t    wr_rec;

  // control and datapath registers
  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [19:0]   s_r, s_nxt;
  logic [19:0]   e_r, e_nxt;
  logic [25:0]   amp_r, amp_nxt;
  logic [KW-1:0] cnt_r, cnt_nxt;
  logic [4:0]    skch_r, skch_nxt;
  logic          skact_r, skact_nxt;
  logic [RW-1:0] nres_r, nres_nxt;
  logic          pend_valid_r, pend_valid_nxt;
  out_item_t     pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_r, out_nxt;
  logic          out_push;

  logic [6:0]  min_s1_r;
  logic [6:0]  min_s2_r;
  logic [19:0] max_s1_r;
  logic [19:0] min_s2w_r;

  logic          in_acc;
  logic          out_free;
  logic [CW-1:0] i_inc;
  logic [CW-1:0] j_inc;
  logic [26:0]   amp_sum;
  logic [25:0]   amp_sat;
  logic signed [21:0] width;
  logic [1:0]    cur_type;
  logic          keep;
  out_item_t     cur_item;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign i_inc = i_r + CW'(1);
  assign j_inc = j_r + CW'(1);

  assign wr_rec.chan  = in_data.channel;
  assign wr_rec.start = in_data.pulse_start & TIME_MASK;
  assign wr_rec.stop  = in_data.pulse_end & TIME_MASK;
  assign wr_rec.amp   = in_data.pulse_amplitude;

  assign amp_sum = {1'b0, amp_r} + 27'(pulse_q.amp);
  assign amp_sat = (amp_sum > 27'(AMP_MAX)) ? AMP_MAX : amp_sum[25:0];

  // signed width so a reversed window classifies as S1
  assign width = $signed({2'b00, e_r}) - $signed({2'b00, s_r});

  always_comb begin
    if (width < $signed({2'b00, max_s1_r})) begin
      cur_type = SIG_S1;
    end else if (width > $signed({2'b00, min_s2w_r})) begin
      cur_type = SIG_S2;
    end else begin
      cur_type = SIG_NONE;
    end
    keep = (cur_type == SIG_S1) ? (cnt_r > KW'(min_s1_r)) : (cnt_r > KW'(min_s2_r));
    cur_item.has_signal    = 1'b1;
    cur_item.sig_start     = s_r;
    cur_item.sig_end       = e_r;
    cur_item.sig_amplitude = amp_r;
    cur_item.pulse_count   = (cnt_r > KW'(127)) ? 7'd127 : cnt_r[6:0];
    cur_item.sig_type      = cur_type;
    cur_item.dropped       = ovf_r;
    cur_item.last          = 1'b0;
  end

  always_comb begin
    state_nxt      = state_r;
    fill_nxt       = fill_r;
    ovf_nxt        = ovf_r;
    i_nxt          = i_r;
    j_nxt          = j_r;
    s_nxt          = s_r;
    e_nxt          = e_r;
    amp_nxt        = amp_r;
    cnt_nxt        = cnt_r;
    skch_nxt       = skch_r;
    skact_nxt      = skact_r;
    nres_nxt       = nres_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_nxt        = out_r;
    out_push       = 1'b0;
    rd_addr        = i_r[AW-1:0];
    pulse_we       = 1'b0;
    flag_we        = 1'b0;
    flag_wd        = 1'b0;
    flag_wa        = fill_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        rd_addr = '0;
        if (in_acc) begin
          if (in_data.op == OP_LOAD) begin
            if (32'(in_data.channel) < CHANNELS) begin
              if (fill_r == CW'(MAX_PULSES)) begin
                ovf_nxt = 1'b1;
              end else begin
                pulse_we = 1'b1;
                flag_we  = 1'b1;
                fill_nxt = fill_r + CW'(1);
              end
            end
          end else if (fill_r == '0) begin
            state_nxt = S_END;
          end else begin
            i_nxt     = '0;
            state_nxt = S_SEED;
          end
        end
      end

      S_SEED: begin
        if (flag_q) begin
          i_nxt   = i_inc;
          rd_addr = i_inc[AW-1:0];
          if (i_inc == fill_r) begin
            state_nxt = S_END;
          end
        end else begin
          s_nxt     = pulse_q.start;
          e_nxt     = pulse_q.stop;
          amp_nxt   = 26'(pulse_q.amp);
          cnt_nxt   = KW'(1);
          skch_nxt  = pulse_q.chan;
          skact_nxt = 1'b1;
          j_nxt     = i_inc;
          rd_addr   = i_inc[AW-1:0];
          state_nxt = (i_inc == fill_r) ? S_FINISH : S_SCAN;
        end
      end

      S_SCAN: begin
        // read the next pulse while this one is judged
        rd_addr = j_inc[AW-1:0];
        j_nxt   = j_inc;
        if (j_inc == fill_r) begin
          state_nxt = S_FINISH;
        end
        if (!(skact_r && pulse_q.chan == skch_r)) begin
          skact_nxt = 1'b0;
          if (!flag_q) begin
            if (pulse_q.start > e_r) begin
              // skip the rest of this channel
              skch_nxt  = pulse_q.chan;
              skact_nxt = 1'b1;
            end else if ((pulse_q.start > s_r && pulse_q.start < e_r) ||
                         (pulse_q.stop > s_r && pulse_q.stop < e_r)) begin
              flag_we = 1'b1;
              flag_wd = 1'b1;
              flag_wa = j_r[AW-1:0];
              cnt_nxt = cnt_r + KW'(1);
              amp_nxt = amp_sat;
              if (pulse_q.start < s_r) begin
                s_nxt = pulse_q.start;
              end
              if (pulse_q.stop > e_r) begin
                e_nxt = pulse_q.stop;
              end
            end
          end
        end
      end

      S_FINISH: begin
        rd_addr = i_inc[AW-1:0];
        if (keep && nres_r < RW'(RESULT_CAP) && pend_valid_r && !out_free) begin
          // hold until the previous result can be pushed
          rd_addr = i_r[AW-1:0];
        end else begin
          if (keep && nres_r < RW'(RESULT_CAP)) begin
            if (pend_valid_r) begin
              out_push = 1'b1;
              out_nxt  = pend_r;
            end
            pend_nxt       = cur_item;
            pend_valid_nxt = 1'b1;
            nres_nxt       = nres_r + RW'(1);
          end
          i_nxt     = i_inc;
          state_nxt = (i_inc == fill_r) ? S_END : S_SEED;
        end
      end

      S_END: begin
        if (out_free) begin
          out_push = 1'b1;
          if (pend_valid_r) begin
            out_nxt = pend_r;
          end else begin
            out_nxt         = '0;
            out_nxt.dropped = ovf_r;
          end
          out_nxt.last   = 1'b1;
          fill_nxt       = '0;
          ovf_nxt        = 1'b0;
          pend_valid_nxt = 1'b0;
          nres_nxt       = '0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_push ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // pulse memory: written on load, read every cycle
  always_ff @(posedge clk) begin
    if (pulse_we) begin
      pulse_mem[fill_r[AW-1:0]] <= wr_rec;
    end
    pulse_q <= pulse_mem[rd_addr];
  end

  // merged flags: cleared per entry on load, set during the scan
  always_ff @(posedge clk) begin
    if (flag_we) begin
      flag_mem[flag_wa] <= flag_wd;
    end
    flag_q <= flag_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      ovf_r        <= 1'b0;
      i_r          <= '0;
      j_r          <= '0;
      skact_r      <= 1'b0;
      nres_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      min_s1_r     <= 7'd1;
      min_s2_r     <= 7'd1;
      max_s1_r     <= 20'd3000;
      min_s2w_r    <= 20'd4000;
    end else begin
      state_r      <= state_nxt;
      fill_r       <= fill_nxt;
      ovf_r        <= ovf_nxt;
      i_r          <= i_nxt;
      j_r          <= j_nxt;
      skact_r      <= skact_nxt;
      nres_r       <= nres_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MIN_S1_PULSES: min_s1_r  <= cfg_data[6:0];
          CFG_MIN_S2_PULSES: min_s2_r  <= cfg_data[6:0];
          CFG_MAX_S1_WIDTH:  max_s1_r  <= cfg_data;
          CFG_MIN_S2_WIDTH:  min_s2w_r <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    s_r    <= s_nxt;
    e_r    <= e_nxt;
    amp_r  <= amp_nxt;
    cnt_r  <= cnt_nxt;
    skch_r <= skch_nxt;
    pend_r <= pend_nxt;
    out_r  <= out_nxt;
  end

`include "pulse_coincidence_clusterer_core_macros.svh"

  `PCC_ASSERT_IMPL(a_fill_bound, 1'b1, fill_r <= CW'(MAX_PULSES))
  `PCC_ASSERT_IMPL(a_scan_bound, state_r == S_SCAN, j_r < fill_r && j_r > i_r)
  `PCC_ASSERT_IMPL(a_merge_in_scan, flag_we && flag_wd, state_r == S_SCAN)
  `PCC_ASSERT_IMPL(a_nres_bound, 1'b1, nres_r <= RW'(RESULT_CAP))
  `PCC_ASSERT_NEXT(a_end_last, state_r == S_END && out_free, out_valid_r && out_r.last)

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for pulse_coincidence_clusterer_core: a directed event table, then random
// PMT events under several threshold settings, checked against the table or an in-bench model.
// Depends on pcc_pkg and the core RTL only.
module tb_top;
  import pcc_pkg::*;

  localparam int STORE_DEPTH   = 64;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 20000;
  localparam int PHASE_ITEMS   = 32;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 50;
  localparam int MAX_REPORTS   = 40;

  typedef enum logic [1:0] {RX_OPEN, RX_HALF, RX_SPARSE, RX_MOSTLY} rx_mode_t;

  typedef struct {
    in_item_t  req;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  // cluster model state
  pulse_rec_t  pulse_mem [STORE_DEPTH];
  bit          merged_mem [STORE_DEPTH];
  int          pulse_fill;
  bit          overflow_seen;
  logic [6:0]  min_s1_count;
  logic [6:0]  min_s2_count;
  logic [19:0] s1_width_limit;
  logic [19:0] s2_width_limit;

  out_item_t   event_clusters [$];
  out_item_t   awaited_clusters [$];
  out_item_t   want_res;
  dir_row_t    dir_rows [$];

  int          burst_left = 0;
  int          hold_requests = 0;
  int          holds_done = 0;
  int          hold_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_mode_left = 0;
  int          quiet_cycles = 0;
  int          mismatch_count = 0;

  pulse_coincidence_clusterer_core #(
    .MAX_PULSES(STORE_DEPTH)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic int channel_run_end(input int j);
    int k;
    k = j + 1;
    while (k < pulse_fill && pulse_mem[k].chan == pulse_mem[j].chan) k++;
    return k;
  endfunction

  task automatic store_pulse(input in_item_t req);
    if (int'(req.channel) >= CHANNELS) return;
    if (pulse_fill >= STORE_DEPTH) begin
      overflow_seen = 1'b1;
      return;
    end
    pulse_mem[pulse_fill].chan  = req.channel;
    pulse_mem[pulse_fill].start = req.pulse_start & TIME_MASK;
    pulse_mem[pulse_fill].stop  = req.pulse_end & TIME_MASK;
    pulse_mem[pulse_fill].amp   = req.pulse_amplitude;
    merged_mem[pulse_fill] = 1'b0;
    pulse_fill++;
  endtask

  // Cluster the stored event into event_clusters, then empty the store.
  task automatic predict_clusters();
    logic [19:0] lo, hi, ts, te;
    int unsigned amp_sum;
    int          count, i, j, span;
    logic [1:0]  kind;
    bit          keep;
    out_item_t   res;
    event_clusters.delete();
    for (i = 0; i < pulse_fill; i++) begin
      if (merged_mem[i]) continue;
      lo      = pulse_mem[i].start;
      hi      = pulse_mem[i].stop;
      amp_sum = 32'(pulse_mem[i].amp);
      count   = 1;
      j = channel_run_end(i);
      while (j < pulse_fill) begin
        ts = pulse_mem[j].start;
        te = pulse_mem[j].stop;
        if (merged_mem[j]) begin
          j++;
        end else if (ts > hi) begin
          // skip the rest of this channel
          j = channel_run_end(j);
        end else begin
          if ((ts > lo && ts < hi) || (te > lo && te < hi)) begin
            merged_mem[j] = 1'b1;
            count++;
            if (ts < lo) lo = ts;
            if (te > hi) hi = te;
            amp_sum += 32'(pulse_mem[j].amp);
            if (amp_sum > 32'(AMP_MAX)) amp_sum = 32'(AMP_MAX);
          end
          j++;
        end
      end
      span = int'(hi) - int'(lo);
      if (span < int'(s1_width_limit)) kind = SIG_S1;
      else if (span > int'(s2_width_limit)) kind = SIG_S2;
      else kind = SIG_NONE;
      keep = (kind == SIG_S1) ? (count > int'(min_s1_count)) : (count > int'(min_s2_count));
      if (keep && event_clusters.size() < RESULT_CAP) begin
        res = '0;
        res.has_signal    = 1'b1;
        res.sig_start     = lo;
        res.sig_end       = hi;
        res.sig_amplitude = amp_sum[25:0];
        res.pulse_count   = (count > 127) ? 7'd127 : 7'(count);
        res.sig_type      = kind;
        res.dropped       = overflow_seen;
        event_clusters.insert(event_clusters.size(), res);
      end
    end
    if (event_clusters.size() == 0) begin
      res = '0;
      res.dropped = overflow_seen;
      event_clusters.insert(event_clusters.size(), res);
    end
    res = event_clusters.pop_back();
    res.last = 1'b1;
    event_clusters.insert(event_clusters.size(), res);
    for (i = 0; i < STORE_DEPTH; i++) merged_mem[i] = 1'b0;
    pulse_fill    = 0;
    overflow_seen = 1'b0;
  endtask

  function automatic in_item_t pulse_req(input int ch, input int s, input int e, input int a);
    in_item_t req;
    req.op              = OP_LOAD;
    req.channel         = 5'(ch);
    req.pulse_start     = 20'(s);
    req.pulse_end       = 20'(e);
    req.pulse_amplitude = 20'(a);
    return req;
  endfunction

  function automatic in_item_t end_req();
    in_item_t req;
    req    = '0;
    req.op = OP_END;
    return req;
  endfunction

  function automatic out_item_t cluster_word(input bit has, input logic [19:0] s,
                                             input logic [19:0] e, input logic [25:0] amp,
                                             input logic [6:0] cnt, input logic [1:0] kind);
    out_item_t res;
    res.has_signal    = has;
    res.sig_start     = s;
    res.sig_end       = e;
    res.sig_amplitude = amp;
    res.pulse_count   = cnt;
    res.sig_type      = kind;
    res.dropped       = 1'b0;
    res.last          = 1'b1;
    return res;
  endfunction

  task automatic add_row(input in_item_t req, input bit typed, input out_item_t want);
    dir_row_t row;
    row.req   = req;
    row.typed = typed;
    row.want  = want;
    dir_rows.insert(dir_rows.size(), row);
  endtask

  // Offer one request in bursts; on acceptance feed the model.
  task automatic send_req(input in_item_t req, input bit typed, input out_item_t want);
    int gap;
    if (burst_left <= 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (in_ready !== 1'b1);
    burst_left--;
    if (req.op == OP_LOAD) begin
      store_pulse(req);
    end else begin
      predict_clusters();
      if (typed) begin
        event_clusters.delete();
        event_clusters.insert(0, want);
      end
      foreach (event_clusters[k])
        awaited_clusters.insert(awaited_clusters.size(), event_clusters[k]);
    end
  endtask

  // One event: loads ordered by channel and start time, or noise, then the end request.
  task automatic send_event(input bit big, inout int items);
    in_item_t    req;
    int          n, k, ch, hop, span, wid;
    bit          noise;
    logic [19:0] base, st;
    noise = ($urandom_range(0, 5) == 0);
    if (big) n = STORE_DEPTH + $urandom_range(1, 4);
    else if ($urandom_range(0, 9) == 0) n = 0;
    else n = $urandom_range(1, 8);
    case ($urandom_range(0, 2))
      0:       span = 300;
      1:       span = 3000;
      default: span = 30000;
    endcase
    base = 20'($urandom);
    ch   = $urandom_range(0, 3);
    st   = base + 20'($urandom_range(0, span));
    for (k = 0; k < n; k++) begin
      req.op = OP_LOAD;
      if (noise) begin
        req.channel     = 5'($urandom);
        req.pulse_start = 20'($urandom);
        req.pulse_end   = 20'($urandom);
      end else begin
        if (k > 0) begin
          if (ch == 31 || $urandom_range(0, 2) == 0) begin
            st = st + 20'($urandom_range(0, span / 4));
          end else begin
            hop = $urandom_range(1, 3);
            ch  = (ch + hop > 31) ? 31 : ch + hop;
            st  = base + 20'($urandom_range(0, span));
          end
        end
        case ($urandom_range(0, 7))
          0:       wid = 0;
          1:       wid = -int'($urandom_range(1, 2000));
          2:       wid = $urandom_range(2900, 4100);
          3:       wid = $urandom_range(4000, 40000);
          default: wid = $urandom_range(1, span);
        endcase
        req.channel     = 5'(ch);
        req.pulse_start = st;
        req.pulse_end   = st + 20'(wid);
      end
      case ($urandom_range(0, 7))
        0:       req.pulse_amplitude = '1;
        1:       req.pulse_amplitude = '0;
        default: req.pulse_amplitude = 20'($urandom);
      endcase
      send_req(req, 1'b0, '0);
    end
    // payload of an end request is don't-care; randomize it anyway
    req.op              = OP_END;
    req.channel         = 5'($urandom);
    req.pulse_start     = 20'($urandom);
    req.pulse_end       = 20'($urandom);
    req.pulse_amplitude = 20'($urandom);
    send_req(req, 1'b0, '0);
    items += n + 1;
  endtask

  task automatic drain_clusters();
    in_valid <= 1'b0;
    while (awaited_clusters.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [19:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_MIN_S1_PULSES: min_s1_count   = val[6:0];
      CFG_MIN_S2_PULSES: min_s2_count   = val[6:0];
      CFG_MAX_S1_WIDTH:  s1_width_limit = val;
      CFG_MIN_S2_WIDTH:  s2_width_limit = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input logic [6:0] s1, input logic [6:0] s2,
                               input logic [19:0] w1, input logic [19:0] w2);
    drain_clusters();
    write_cfg(CFG_MIN_S1_PULSES, 20'(s1));
    write_cfg(CFG_MIN_S2_PULSES, 20'(s2));
    write_cfg(CFG_MAX_S1_WIDTH, w1);
    write_cfg(CFG_MIN_S2_WIDTH, w2);
    cfg_we <= 1'b0;
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) $display("mismatch at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [25:0] got, input logic [25:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  initial begin : stimulus
    int       phase, phase_items;
    min_s1_count   = 7'd1;
    min_s2_count   = 7'd1;
    s1_width_limit = 20'd3000;
    s2_width_limit = 20'd4000;
    pulse_fill     = 0;
    overflow_seen  = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) merged_mem[i] = 1'b0;

    // empty event, then a lone pulse that falls short of the count minimum
    add_row(end_req(), 1'b1, cluster_word(1'b0, 20'd0, 20'd0, 26'd0, 7'd0, SIG_S1));
    add_row(pulse_req(0, 100, 200, 5), 1'b0, '0);
    add_row(end_req(), 1'b1, cluster_word(1'b0, 20'd0, 20'd0, 26'd0, 7'd0, SIG_S1));
    // two overlapping channels make a short S1
    add_row(pulse_req(0, 100, 200, 5), 1'b0, '0);
    add_row(pulse_req(1, 150, 250, 7), 1'b0, '0);
    add_row(end_req(), 1'b1, cluster_word(1'b1, 20'd100, 20'd250, 26'd12, 7'd2, SIG_S1));
    // extremes: channel 31, full-scale times and amplitudes, wide S2
    add_row(pulse_req(0, 0, 5000, 'hFFFFF), 1'b0, '0);
    add_row(pulse_req(31, 10, 'hFFFFF, 'hFFFFF), 1'b0, '0);
    add_row(end_req(), 1'b1,
            cluster_word(1'b1, 20'd0, 20'hFFFFF, 26'h1FFFFE, 7'd2, SIG_S2));
    // reversed pulse joins a normal window
    add_row(pulse_req(2, 1000, 2000, 1), 1'b0, '0);
    add_row(pulse_req(3, 1500, 1200, 2), 1'b0, '0);
    add_row(end_req(), 1'b1, cluster_word(1'b1, 20'd1000, 20'd2000, 26'd3, 7'd2, SIG_S1));
    // width between the limits gives neither type
    add_row(pulse_req(0, 0, 3500, 1), 1'b0, '0);
    add_row(pulse_req(1, 100, 200, 1), 1'b0, '0);
    add_row(end_req(), 1'b1, cluster_word(1'b1, 20'd0, 20'd3500, 26'd2, 7'd2, SIG_NONE));
    // late start skips the rest of its channel
    add_row(pulse_req(0, 100, 200, 4), 1'b0, '0);
    add_row(pulse_req(1, 300, 400, 0), 1'b0, '0);
    add_row(pulse_req(1, 150, 180, 9), 1'b0, '0);
    add_row(pulse_req(2, 120, 190, 6), 1'b0, '0);
    add_row(end_req(), 1'b0, '0);
    // two clusters in one event, one at the top of the time range
    add_row(pulse_req(0, 10, 20, 1), 1'b0, '0);
    add_row(pulse_req(0, 'hFFFF0, 'hFFFFF, 0), 1'b0, '0);
    add_row(pulse_req(1, 15, 30, 2), 1'b0, '0);
    add_row(pulse_req(1, 'hFFFF5, 'hFFFFE, 3), 1'b0, '0);
    add_row(end_req(), 1'b0, '0);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[r]) send_req(dir_rows[r].req, dir_rows[r].typed, dir_rows[r].want);

    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: apply_setting(7'd0, 7'd0, 20'd3000, 20'd4000);
        1: apply_setting(7'd64, 7'd64, 20'd0, 20'hFFFFF);
        2: apply_setting(7'd0, 7'd1, 20'hFFFFF, 20'd0);
        3: apply_setting(7'($urandom_range(0, 2)), 7'($urandom_range(0, 2)), 20'd0, 20'd0);
        default: apply_setting(7'($urandom_range(0, 4)), 7'($urandom_range(0, 4)),
                               20'($urandom_range(0, 6000)), 20'($urandom_range(0, 8000)));
      endcase
      // stall the result side while requests keep coming
      if (phase == 0) hold_requests++;
      phase_items = 0;
      if (phase == 2) send_event(1'b1, phase_items);
      while (phase_items < PHASE_ITEMS) send_event(1'b0, phase_items);
    end

    drain_clusters();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Receiver: changing stall modes, plus a long hold when asked.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_ready  <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(16, 96);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_HALF:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (awaited_clusters.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: %h", out_data));
      end else begin
        want_res = awaited_clusters.pop_front();
        check_field("has_signal", 26'(out_data.has_signal), 26'(want_res.has_signal));
        check_field("sig_start", 26'(out_data.sig_start), 26'(want_res.sig_start));
        check_field("sig_end", 26'(out_data.sig_end), 26'(want_res.sig_end));
        check_field("sig_amplitude", out_data.sig_amplitude, want_res.sig_amplitude);
        check_field("pulse_count", 26'(out_data.pulse_count), 26'(want_res.pulse_count));
        check_field("sig_type", 26'(out_data.sig_type), 26'(want_res.sig_type));
        check_field("dropped", 26'(out_data.dropped), 26'(want_res.dropped));
        check_field("last", 26'(out_data.last), 26'(want_res.last));
      end
    end
  end

  // End the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

endmodule

// ===== pulse_coincidence_clusterer_core.f =====
+incdir+rtl
rtl/pcc_pkg.sv
rtl/pulse_coincidence_clusterer_core.sv
tb/tb_top.sv
